// ===== hdl/bmpmc_pkg.sv =====
package bmpmc_pkg;

    // default geometry
    localparam int NUM_BANKS_DEF  = 8;
    localparam int BANK_WORDS_DEF = 1024;
    localparam int WORD_BYTES     = 4;
    localparam int WORD_W         = 8 * WORD_BYTES;

    // fixed field widths
    localparam int ADDR_W   = 13;
    localparam int FUNC_W   = 2;
    localparam int MODE_W   = 2;
    localparam int MODES_W  = 16;
    localparam int CNT_W    = 16;
    localparam int LAT_W    = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // stream widths (tdata in whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

    // memory fill value after reset
    localparam logic [WORD_W-1:0] FILL_WORD = {WORD_BYTES{8'hAA}};

    // bank power modes
    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE   = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] REQ_RST   = 16'h5555;
    localparam logic [CFG_W-1:0] IDLE_RST  = 16'd16;
    localparam logic [CFG_W-1:0] SLEEP_RST = 16'd2;
    localparam logic [CFG_W-1:0] WAKE_RST  = 16'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

endpackage

// ===== hdl/banked_memory_power_mode_control.sv =====
// Banked word memory with per-bank power modes (off, retention, active).
// After reset the block runs a clearing pass that writes 0xAAAAAAAA to
// every word, one word per cycle (NUM_BANKS*BANK_WORDS words, capped at
// 8192; 8192 words at the defaults); s_tready stays low during the pass,
// configuration writes are taken throughout. Afterwards one beat (tick,
// read or write) is taken per cycle and its result beat appears in the next
// cycle from the registered read port of the word memory; the per-bank
// mode timers are updated in the same cycle as acceptance, so back-to-back
// beats see each other's effects. A stalled result holds s_tready low.
// Configuration registers: 0 manual_control, 1 requested_modes,
// 2 idle_timeout_cycles, 3 sleep_delay_cycles, 4 wake_delay_cycles.
module banked_memory_power_mode_control #(
    parameter int NUM_BANKS  = bmpmc_pkg::NUM_BANKS_DEF,
    parameter int BANK_WORDS = bmpmc_pkg::BANK_WORDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input beat
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [12:0] word_address, [44:13] write_data
    input  logic [bmpmc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] func
    input  logic [bmpmc_pkg::S_TUSER_W-1:0]    s_tuser,
    // result beat
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] read_data, [48:32] extra_latency, [64:49] bank_modes
    output logic [bmpmc_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] access_error
    output logic [bmpmc_pkg::M_TUSER_W-1:0]    m_tuser,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [bmpmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmpmc_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int ADDR_W      = bmpmc_pkg::ADDR_W;
    localparam int WORD_W      = bmpmc_pkg::WORD_W;
    localparam int MODE_W      = bmpmc_pkg::MODE_W;
    localparam int CNT_W       = bmpmc_pkg::CNT_W;
    localparam int LAT_W       = bmpmc_pkg::LAT_W;
    localparam int MODES_W     = bmpmc_pkg::MODES_W;
    localparam int TOTAL_WORDS = NUM_BANKS * BANK_WORDS;
    localparam int ADDR_SPAN   = 1 << ADDR_W;
    localparam int MEM_DEPTH   = (TOTAL_WORDS < ADDR_SPAN) ? TOTAL_WORDS : ADDR_SPAN;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int BANK_W      = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int PAD_W       = bmpmc_pkg::M_TDATA_W - WORD_W - LAT_W - MODES_W;

    // input field unpack
    logic [bmpmc_pkg::FUNC_W-1:0] in_func;
    logic [ADDR_W-1:0]            in_addr;
    logic [WORD_W-1:0]            in_wdata;

    assign in_func  = s_tuser[bmpmc_pkg::FUNC_W-1:0];
    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_wdata = s_tdata[ADDR_W +: WORD_W];

    // controller state and clearing pass
    bmpmc_pkg::state_t state_reg;
    logic [MEM_AW-1:0] clr_addr_reg;

    // configuration
    logic                          manual_reg;
    logic [bmpmc_pkg::CFG_W-1:0]   req_reg;
    logic [CNT_W-1:0]              idle_to_reg;
    logic [CNT_W-1:0]              sleep_reg;
    logic [CNT_W-1:0]              wake_reg;

    // per-bank power state
    logic [MODE_W-1:0] mode_reg [NUM_BANKS];
    logic [MODE_W-1:0] tgt_reg  [NUM_BANKS];
    logic [CNT_W-1:0]  tcnt_reg [NUM_BANKS];
    logic [LAT_W-1:0]  idle_reg [NUM_BANKS];
    logic [MODE_W-1:0] mode_next [NUM_BANKS];
    logic [MODE_W-1:0] tgt_next  [NUM_BANKS];
    logic [CNT_W-1:0]  tcnt_next [NUM_BANKS];
    logic [LAT_W-1:0]  idle_next [NUM_BANKS];

    // result register
    logic                out_valid_reg;
    logic                out_rd_reg;
    logic [LAT_W-1:0]    out_lat_reg;
    logic                out_err_reg;
    logic [MODES_W-1:0]  out_modes_reg;
    logic [WORD_W-1:0]   mem_rdata_reg;

    // word memory
    logic [WORD_W-1:0] mem [MEM_DEPTH];

    logic               clearing;
    logic               in_fire;
    logic               is_access;
    logic               in_range;
    logic [BANK_W-1:0]  bank_idx;
    logic [MODE_W-1:0]  cur_mode;
    logic               acc_ok;
    logic               acc_err;
    logic [LAT_W-1:0]   acc_lat;
    logic               drop_all;
    logic [LAT_W-1:0]   idle_load;
    logic [MODES_W-1:0] modes_next;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [MEM_AW-1:0]  item_idx;

    assign clearing = (state_reg == bmpmc_pkg::ST_CLEAR);
    assign s_tready = (state_reg == bmpmc_pkg::ST_RUN) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    // address decode
    assign is_access = (in_func == bmpmc_pkg::FUNC_READ) || (in_func == bmpmc_pkg::FUNC_WRITE);
    assign in_range  = (32'(in_addr) < 32'(TOTAL_WORDS));
    assign item_idx  = in_addr[MEM_AW-1:0];
    assign cur_mode  = mode_reg[bank_idx];
    assign idle_load = LAT_W'(idle_to_reg) + LAT_W'(1);

    // bank select: highest bank boundary at or below the address
    always_comb begin
        bank_idx = '0;
        for (int b = 1; b < NUM_BANKS; b++) begin
            if (32'(in_addr) >= 32'(b * BANK_WORDS))
                bank_idx = BANK_W'(b);
        end
    end

    // access outcome
    always_comb begin
        acc_ok  = 1'b0;
        acc_err = 1'b0;
        acc_lat = '0;
        if (is_access) begin
            if (!in_range) begin
                acc_err = 1'b1;
            end else if (cur_mode == bmpmc_pkg::MODE_ACT) begin
                acc_ok  = 1'b1;
                acc_lat = LAT_W'(1);
            end else if (cur_mode == bmpmc_pkg::MODE_RET && !manual_reg) begin
                acc_ok  = 1'b1;
                acc_lat = LAT_W'(wake_reg) + LAT_W'(1);
            end else begin
                acc_err = 1'b1;
            end
        end
    end

    // leaving auto/manual drops every pending move and idle timer
    assign drop_all = cfg_we && (cfg_index == bmpmc_pkg::REG_MANUAL) &&
                      (cfg_wdata[0] != manual_reg);

    // per-bank next state: ticks, accesses, mode change
    always_comb begin
        logic [MODE_W-1:0] r;
        logic [CNT_W-1:0]  dly;
        logic [CNT_W-1:0]  dec;
        for (int b = 0; b < NUM_BANKS; b++) begin
            mode_next[b] = mode_reg[b];
            tgt_next[b]  = tgt_reg[b];
            tcnt_next[b] = tcnt_reg[b];
            idle_next[b] = idle_reg[b];
            r   = req_reg[2*b +: 2];
            dly = (r == bmpmc_pkg::MODE_ACT) ? wake_reg : sleep_reg;
            dec = tcnt_reg[b] - CNT_W'(1);
            if (in_fire && in_func == bmpmc_pkg::FUNC_TICK) begin
                if (tcnt_reg[b] != '0) begin
                    // pending move counts down
                    tcnt_next[b] = dec;
                    if (dec == '0) begin
                        mode_next[b] = tgt_reg[b];
                        if (!manual_reg && tgt_reg[b] == bmpmc_pkg::MODE_ACT)
                            idle_next[b] = idle_load;
                    end
                end else if (manual_reg) begin
                    // follow the requested mode
                    if (r != bmpmc_pkg::MODE_NONE && r != mode_reg[b]) begin
                        tgt_next[b] = r;
                        if (dly == '0) begin
                            mode_next[b] = r;
                        end else begin
                            tcnt_next[b] = dly;
                        end
                    end
                end else if (idle_reg[b] != '0) begin
                    // idle timer; expiry starts a sleep to retention
                    if (idle_reg[b] == LAT_W'(1) || idle_reg[b] == LAT_W'(2)) begin
                        idle_next[b] = '0;
                        tgt_next[b]  = bmpmc_pkg::MODE_RET;
                        if (sleep_reg == '0)
                            mode_next[b] = bmpmc_pkg::MODE_RET;
                        else
                            tcnt_next[b] = sleep_reg;
                    end else begin
                        idle_next[b] = idle_reg[b] - LAT_W'(1);
                    end
                end
            end else if (in_fire && acc_ok && BANK_W'(b) == bank_idx) begin
                if (mode_reg[b] == bmpmc_pkg::MODE_ACT) begin
                    // active in auto mode: cancel a pending sleep, restart idle timer
                    if (!manual_reg) begin
                        tcnt_next[b] = '0;
                        tgt_next[b]  = bmpmc_pkg::MODE_ACT;
                        idle_next[b] = idle_load;
                    end
                end else begin
                    // retention in auto mode: start waking unless already waking
                    idle_next[b] = '0;
                    if (tcnt_reg[b] == '0 || tgt_reg[b] != bmpmc_pkg::MODE_ACT) begin
                        tgt_next[b] = bmpmc_pkg::MODE_ACT;
                        if (wake_reg == '0) begin
                            tcnt_next[b] = '0;
                            mode_next[b] = bmpmc_pkg::MODE_ACT;
                            idle_next[b] = idle_load;
                        end else begin
                            tcnt_next[b] = wake_reg;
                        end
                    end
                end
            end
            if (drop_all) begin
                tcnt_next[b] = '0;
                tgt_next[b]  = mode_reg[b];
                idle_next[b] = '0;
            end
        end
    end

    // mode word after the item
    always_comb begin
        modes_next = '0;
        for (int b = 0; b < NUM_BANKS; b++)
            modes_next[2*b +: 2] = mode_next[b];
    end

    // bank state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                mode_reg[b] <= bmpmc_pkg::MODE_RET;
                tgt_reg[b]  <= bmpmc_pkg::MODE_RET;
                tcnt_reg[b] <= '0;
                idle_reg[b] <= '0;
            end
        end else begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                mode_reg[b] <= mode_next[b];
                tgt_reg[b]  <= tgt_next[b];
                tcnt_reg[b] <= tcnt_next[b];
                idle_reg[b] <= idle_next[b];
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_reg  <= 1'b0;
            req_reg     <= bmpmc_pkg::REQ_RST;
            idle_to_reg <= bmpmc_pkg::IDLE_RST;
            sleep_reg   <= bmpmc_pkg::SLEEP_RST;
            wake_reg    <= bmpmc_pkg::WAKE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                bmpmc_pkg::REG_MANUAL: manual_reg  <= cfg_wdata[0];
                bmpmc_pkg::REG_REQ:    req_reg     <= cfg_wdata;
                bmpmc_pkg::REG_IDLE:   idle_to_reg <= cfg_wdata;
                bmpmc_pkg::REG_SLEEP:  sleep_reg   <= cfg_wdata;
                bmpmc_pkg::REG_WAKE:   wake_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clearing pass, then normal operation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bmpmc_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            case (state_reg)
                bmpmc_pkg::ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + MEM_AW'(1);
                    if (clr_addr_reg == MEM_AW'(MEM_DEPTH - 1))
                        state_reg <= bmpmc_pkg::ST_RUN;
                end
                bmpmc_pkg::ST_RUN: state_reg <= bmpmc_pkg::ST_RUN;
                default: state_reg <= bmpmc_pkg::ST_CLEAR;
            endcase
        end
    end

    // memory write port: fill during clearing, else item writes
    assign mem_we    = clearing || (in_fire && acc_ok && in_func == bmpmc_pkg::FUNC_WRITE);
    assign mem_waddr = clearing ? clr_addr_reg : item_idx;
    assign mem_wdata = clearing ? bmpmc_pkg::FILL_WORD : in_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (in_fire && acc_ok && in_func == bmpmc_pkg::FUNC_READ)
            mem_rdata_reg <= mem[item_idx];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_rd_reg    <= acc_ok && (in_func == bmpmc_pkg::FUNC_READ);
            out_lat_reg   <= acc_lat;
            out_err_reg   <= acc_err;
            out_modes_reg <= modes_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_modes_reg, out_lat_reg,
                       (out_rd_reg ? mem_rdata_reg : {WORD_W{1'b0}})};
    assign m_tuser  = out_err_reg;

endmodule

// ===== test/bank_power_checker.sv =====
// Watches the input, result and register-write ports of the banked memory,
// keeps its own copy of the memory and per-bank power state, and compares
// every result beat against the predicted one.
module bank_power_checker
    import bmpmc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    input  logic [S_TUSER_W-1:0]    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_W-1:0]    m_tdata,
    input  logic [M_TUSER_W-1:0]    m_tuser,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    output int                      fail_count,
    output int                      pending_count,
    output int                      checked_count,
    output int                      error_count
);

    localparam int BANKS       = NUM_BANKS_DEF;
    localparam int TOTAL_WORDS = NUM_BANKS_DEF * BANK_WORDS_DEF;

    typedef struct packed {
        logic [WORD_W-1:0]  rdata;
        logic [LAT_W-1:0]   lat;
        logic               err;
        logic [MODES_W-1:0] modes;
    } bank_result_t;

    // shadow memory and power state
    logic [WORD_W-1:0] word_mem [TOTAL_WORDS];
    logic [MODE_W-1:0] mode_q   [BANKS];
    logic [MODE_W-1:0] move_tgt [BANKS];
    logic [CNT_W-1:0]  move_cnt [BANKS];
    logic [LAT_W-1:0]  idle_cnt [BANKS];

    // shadow configuration
    logic              manual_q;
    logic [CFG_W-1:0]  req_q;
    logic [CFG_W-1:0]  idle_to_q;
    logic [CFG_W-1:0]  sleep_q;
    logic [CFG_W-1:0]  wake_q;

    bank_result_t pending_results [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 40)
            $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // bank settled in a new mode: in auto mode an active bank arms its idle timer
    task automatic reach_mode(input int b);
        if (!manual_q && mode_q[b] == MODE_ACT)
            idle_cnt[b] = {1'b0, idle_to_q} + 17'd1;
    endtask

    task automatic start_move(input int b, input logic [MODE_W-1:0] tgt,
                              input logic [CNT_W-1:0] delay);
        move_tgt[b] = tgt;
        move_cnt[b] = delay;
        if (delay == '0) begin
            mode_q[b] = tgt;
            reach_mode(b);
        end
    endtask

    task automatic tick_bank(input int b);
        logic [MODE_W-1:0] want;
        if (move_cnt[b] != '0) begin
            // pending transition always finishes first
            move_cnt[b] = move_cnt[b] - 1'b1;
            if (move_cnt[b] == '0) begin
                mode_q[b] = move_tgt[b];
                reach_mode(b);
            end
        end else if (manual_q) begin
            want = req_q[2*b +: 2];
            if (want != MODE_NONE && want != mode_q[b])
                start_move(b, want, (want == MODE_ACT) ? wake_q : sleep_q);
        end else if (idle_cnt[b] != '0) begin
            if (idle_cnt[b] > 17'd1)
                idle_cnt[b] = idle_cnt[b] - 1'b1;
            if (idle_cnt[b] == 17'd1) begin
                idle_cnt[b] = '0;
                start_move(b, MODE_RET, sleep_q);
            end
        end
    endtask

    // expected result of one input beat; updates the shadow state
    task automatic predict_bank_access(input logic [FUNC_W-1:0] func,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [WORD_W-1:0] wdata,
                                       output bank_result_t r);
        int  b;
        logic ok;
        r  = '0;
        ok = 1'b0;
        if (func == FUNC_TICK) begin
            for (b = 0; b < BANKS; b++)
                tick_bank(b);
        end else if (func == FUNC_READ || func == FUNC_WRITE) begin
            b = int'(addr) / BANK_WORDS_DEF;
            if (int'(addr) >= TOTAL_WORDS) begin
                r.err = 1'b1;
            end else if (mode_q[b] == MODE_ACT) begin
                ok    = 1'b1;
                r.lat = 17'd1;
                if (!manual_q) begin
                    // any pending sleep is cancelled
                    move_cnt[b] = '0;
                    move_tgt[b] = MODE_ACT;
                    idle_cnt[b] = {1'b0, idle_to_q} + 17'd1;
                end
            end else if (mode_q[b] == MODE_RET && !manual_q) begin
                ok          = 1'b1;
                r.lat       = {1'b0, wake_q} + 17'd1;
                idle_cnt[b] = '0;
                if (move_cnt[b] == '0 || move_tgt[b] != MODE_ACT)
                    start_move(b, MODE_ACT, wake_q);
            end else begin
                r.err = 1'b1;
            end
            if (ok) begin
                if (func == FUNC_READ)
                    r.rdata = word_mem[addr];
                else
                    word_mem[addr] = wdata;
            end
        end
        for (b = 0; b < BANKS; b++)
            r.modes[2*b +: 2] = mode_q[b];
    endtask

    always @(posedge aclk) begin
        bank_result_t want;
        bank_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_WORDS; i++)
                word_mem[i] = FILL_WORD;
            for (int b = 0; b < BANKS; b++) begin
                mode_q[b]   = MODE_RET;
                move_tgt[b] = MODE_RET;
                move_cnt[b] = '0;
                idle_cnt[b] = '0;
            end
            manual_q  = 1'b0;
            req_q     = REQ_RST;
            idle_to_q = IDLE_RST;
            sleep_q   = SLEEP_RST;
            wake_q    = WAKE_RST;
            pending_results.delete();
        end else begin
            // result beat against oldest expectation
            if (m_tvalid && m_tready) begin
                got.rdata = m_tdata[31:0];
                got.lat   = m_tdata[48:32];
                got.modes = m_tdata[64:49];
                got.err   = m_tuser[0];
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_tdata[63:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (want.err)
                        error_count++;
                    if (got.rdata !== want.rdata)
                        report_mismatch("read_data", 64'(got.rdata), 64'(want.rdata));
                    if (got.lat !== want.lat)
                        report_mismatch("extra_latency", 64'(got.lat), 64'(want.lat));
                    if (got.err !== want.err)
                        report_mismatch("access_error", 64'(got.err), 64'(want.err));
                    if (got.modes !== want.modes)
                        report_mismatch("bank_modes", 64'(got.modes), 64'(want.modes));
                end
            end
            // accepted input beat
            if (s_tvalid && s_tready) begin
                predict_bank_access(s_tuser, s_tdata[12:0], s_tdata[44:13], want);
                pending_results = {pending_results, want};
            end
            // register write
            if (cfg_we) begin
                case (cfg_index)
                    REG_MANUAL: begin
                        if (cfg_wdata[0] != manual_q) begin
                            manual_q = cfg_wdata[0];
                            for (int b = 0; b < BANKS; b++) begin
                                move_cnt[b] = '0;
                                move_tgt[b] = mode_q[b];
                                idle_cnt[b] = '0;
                            end
                        end
                    end
                    REG_REQ:   req_q     = cfg_wdata;
                    REG_IDLE:  idle_to_q = cfg_wdata;
                    REG_SLEEP: sleep_q   = cfg_wdata;
                    REG_WAKE:  wake_q    = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending_count = pending_results.size();
    end

endmodule

// ===== test/banked_memory_power_mode_control_tb.sv =====
module banked_memory_power_mode_control_tb;
    import bmpmc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BEATS = 112;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    int fail_count;
    int pending_count;
    int checked_count;
    int error_count;
    int idle_pct;
    int stall_pct;
    int beats_sent;
    int settings_used;
    int cycle_count;

    banked_memory_power_mode_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bank_power_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .error_count   (error_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // one input beat; returns at the falling edge after it was taken
    task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] wdata);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {3'b000, wdata, addr};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
    endtask

    // stop sending and wait for every result to come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
    endtask

    initial begin
        int          hot_bank;
        int          pick;
        logic [FUNC_W-1:0] f;
        logic [ADDR_W-1:0] a;

        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = FUNC_TICK;
        cfg_we        = 1'b0;
        cfg_index     = REG_MANUAL;
        cfg_wdata     = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        beats_sent    = 0;
        settings_used = 1;
        aresetn       = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // auto mode at reset settings: wake on access, re-access while waking
        send_beat(FUNC_READ, 13'd0, 32'h0);
        send_beat(FUNC_READ, 13'd5, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        send_beat(FUNC_WRITE, 13'd0, 32'hFFFF_FFFF);
        send_beat(FUNC_READ, 13'd0, 32'h0);
        send_beat(FUNC_WRITE, 13'h1FFF, 32'h0);
        send_beat(FUNC_NOP, 13'h1FFF, 32'hFFFF_FFFF);

        // zero timeout and wake; access during a pending sleep cancels it
        drain();
        write_reg(REG_IDLE, 16'd0);
        write_reg(REG_SLEEP, 16'd3);
        write_reg(REG_WAKE, 16'd0);
        cfg_we = 1'b0;
        settings_used++;
        send_beat(FUNC_READ, 13'd1024, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        send_beat(FUNC_READ, 13'd1024, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);

        // manual control with mixed requests, incl. the hold code;
        // then change requests while moves are still in flight
        drain();
        write_reg(REG_MANUAL, 16'd1);
        write_reg(REG_REQ, 16'h92E4);
        cfg_we = 1'b0;
        settings_used++;
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        drain();
        write_reg(REG_REQ, 16'h0000);
        cfg_we = 1'b0;
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);
        send_beat(FUNC_READ, 13'd0, 32'h0);
        send_beat(FUNC_READ, 13'd1024, 32'h0);
        send_beat(FUNC_WRITE, 13'd2048, 32'h1234_5678);
        send_beat(FUNC_READ, 13'd2048, 32'h0);

        // back to auto: pending moves dropped, off banks stay off
        drain();
        write_reg(REG_MANUAL, 16'd0);
        cfg_we = 1'b0;
        settings_used++;
        send_beat(FUNC_READ, 13'd0, 32'h0);
        send_beat(FUNC_TICK, 13'd0, 32'h0);

        // random phases, each with its own settings and idling pattern
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            case (p)
                0: begin
                    write_reg(REG_MANUAL, 16'd0);
                    write_reg(REG_REQ, 16'($urandom()));
                    write_reg(REG_IDLE, 16'd3);
                    write_reg(REG_SLEEP, 16'd1);
                    write_reg(REG_WAKE, 16'd1);
                end
                1: begin
                    write_reg(REG_MANUAL, 16'd1);
                    write_reg(REG_REQ, 16'hAAAA);
                    write_reg(REG_IDLE, 16'd0);
                    write_reg(REG_SLEEP, 16'd0);
                    write_reg(REG_WAKE, 16'd0);
                end
                2: begin
                    write_reg(REG_MANUAL, 16'd0);
                    write_reg(REG_REQ, 16'hFFFF);
                    write_reg(REG_IDLE, 16'hFFFF);
                    write_reg(REG_SLEEP, 16'hFFFF);
                    write_reg(REG_WAKE, 16'hFFFF);
                end
                3, 5: begin
                    write_reg(REG_MANUAL, 16'd1);
                    write_reg(REG_REQ, 16'($urandom()));
                    write_reg(REG_IDLE, 16'($urandom_range(0, 6)));
                    write_reg(REG_SLEEP, 16'($urandom_range(0, 3)));
                    write_reg(REG_WAKE, 16'($urandom_range(0, 3)));
                end
                6: begin
                    write_reg(REG_MANUAL, 16'd1);
                    write_reg(REG_REQ, 16'hAAAA);
                    write_reg(REG_WAKE, 16'd2);
                    write_reg(REG_SLEEP, 16'd2);
                    write_reg(REG_IDLE, 16'd4);
                end
                default: begin
                    write_reg(REG_MANUAL, 16'd0);
                    write_reg(REG_REQ, 16'($urandom()));
                    write_reg(REG_IDLE, 16'($urandom_range(0, 12)));
                    write_reg(REG_SLEEP, 16'($urandom_range(0, 4)));
                    write_reg(REG_WAKE, 16'($urandom_range(0, 4)));
                end
            endcase
            cfg_we = 1'b0;
            settings_used++;
            hot_bank = $urandom_range(0, NUM_BANKS_DEF - 1);

            for (int n = 0; n < PHASE_BEATS; n++) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    f = FUNC_TICK;
                else if (pick < 68)
                    f = FUNC_READ;
                else if (pick < 96)
                    f = FUNC_WRITE;
                else
                    f = FUNC_NOP;
                // half the accesses go to one bank so timers get exercised
                if ($urandom_range(1) == 0)
                    a = ADDR_W'(hot_bank * BANK_WORDS_DEF + $urandom_range(0, 15));
                else
                    a = ADDR_W'($urandom_range(0, 8191));
                send_beat(f, a, $urandom());
            end
        end

        drain();
        repeat (4) @(negedge aclk);
        $display("%0d beats sent under %0d register settings in %0d cycles",
                 beats_sent, settings_used, cycle_count);
        $display("%0d results compared, %0d of them flagged as access errors",
                 checked_count, error_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
